/* rtl/rmc_pkg.sv */
// shared types, character codes and helper functions for the rmc sentence parser
// no dependencies; used by every rtl file of the block
`timescale 1ns / 1ps

package rmc_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIX = 2'd1,
    ST_SHORT = 2'd2,
    ST_CSUM  = 2'd3
  } status_t;

  localparam int HDR_LEN = 6;
  localparam int NUM_DIGITS = 12;

  localparam logic [0:HDR_LEN-1][7:0] HDR_CHARS = {8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};
  // xor of the header letters after '$'
  localparam logic [7:0] HDR_XOR = 8'h47 ^ 8'h50 ^ 8'h52 ^ 8'h4D ^ 8'h43;

  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_STAR   = 8'h2A;
  localparam logic [7:0] CHR_COMMA  = 8'h2C;
  localparam logic [7:0] CHR_FIX    = 8'h41;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_NINE   = 8'h39;

  localparam logic [3:0] FIELD_TIME   = 4'd1;
  localparam logic [3:0] FIELD_STATUS = 4'd2;
  localparam logic [3:0] FIELD_DATE   = 4'd9;

  localparam logic [11:0] YEAR_BASE = 12'd2000;

  // closed sentence handed from parser to clock decision
  typedef struct packed {
    status_t                         status;
    logic [NUM_DIGITS-1:0][3:0]      digits;
  } evt_t;

  // bit 4 is the valid flag, bits 3:0 the nibble
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  function automatic logic [7:0] pair_value(input logic [3:0] hi, input logic [3:0] lo);
    logic [7:0] r;
    r = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
    return r;
  endfunction

endpackage

/* rtl/rmc_front.sv */
// byte parser: header hunt, field tracking, checksum and sentence classification
// depends on rmc_pkg
`timescale 1ns / 1ps

module rmc_front #(
  parameter int MAX_SENTENCE_LEN = 127
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic [6:0]        min_sentence_length,
  input  logic              evt_full,
  output logic              evt_push,
  output rmc_pkg::evt_t     evt_data
);

  localparam int LEN_W = $clog2(MAX_SENTENCE_LEN + 1);

  logic [2:0]       hdr_pos;
  logic             in_sentence;
  logic [3:0]       comma_count;
  logic [2:0]       char_in_field;
  logic [LEN_W-1:0] sentence_length;
  logic [7:0]       xor_acc;
  logic [1:0]       after_star;
  logic [7:0]       rx_csum;
  logic             bad_tail;
  logic             fix_active;
  logic [rmc_pkg::NUM_DIGITS-1:0][3:0] digits;

  logic       accept;
  logic [2:0] hunt_pos;
  logic [4:0] hex;
  logic [3:0] digit;
  logic [3:0] dig_idx;
  rmc_pkg::status_t close_status;

  assign in_ready = !evt_full;
  assign accept   = in_valid && in_ready;
  assign hunt_pos = (hdr_pos >= 3'(rmc_pkg::HDR_LEN)) ? 3'd0 : hdr_pos;
  assign hex      = rmc_pkg::hex_decode(data_byte);
  assign digit    = (data_byte inside {[rmc_pkg::CHR_ZERO:rmc_pkg::CHR_NINE]}) ?
                    4'(data_byte - rmc_pkg::CHR_ZERO) : 4'd0;
  assign dig_idx  = {1'b0, char_in_field} + ((comma_count == rmc_pkg::FIELD_DATE) ? 4'd6 : 4'd0);

  always_comb begin
    if (!fix_active) begin
      close_status = rmc_pkg::ST_NOFIX;
    end else if (9'(sentence_length) < 9'(min_sentence_length)) begin
      close_status = rmc_pkg::ST_SHORT;
    end else if (bad_tail || after_star != 2'd3 || rx_csum != xor_acc) begin
      close_status = rmc_pkg::ST_CSUM;
    end else begin
      close_status = rmc_pkg::ST_OK;
    end
  end

  assign evt_push        = accept && in_sentence && data_byte == rmc_pkg::CHR_CR;
  assign evt_data.status = close_status;
  assign evt_data.digits = digits;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos         <= 3'd0;
      in_sentence     <= 1'b0;
      comma_count     <= 4'd0;
      char_in_field   <= 3'd0;
      sentence_length <= '0;
      xor_acc         <= 8'd0;
      after_star      <= 2'd0;
      rx_csum         <= 8'd0;
      bad_tail        <= 1'b0;
      fix_active      <= 1'b0;
      digits          <= '0;
    end else if (accept) begin
      if (!in_sentence) begin
        // header hunt
        if (data_byte == rmc_pkg::HDR_CHARS[hunt_pos]) begin
          if (hunt_pos == 3'(rmc_pkg::HDR_LEN - 1)) begin
            in_sentence     <= 1'b1;
            hdr_pos         <= 3'(rmc_pkg::HDR_LEN);
            comma_count     <= 4'd0;
            char_in_field   <= 3'd0;
            sentence_length <= LEN_W'(rmc_pkg::HDR_LEN);
            xor_acc         <= rmc_pkg::HDR_XOR;
            after_star      <= 2'd0;
            rx_csum         <= 8'd0;
            bad_tail        <= 1'b0;
            fix_active      <= 1'b0;
            digits          <= '0;
          end else begin
            hdr_pos <= hunt_pos + 3'd1;
          end
        end else begin
          hdr_pos <= (data_byte == rmc_pkg::CHR_DOLLAR) ? 3'd1 : 3'd0;
        end
      end else if (data_byte == rmc_pkg::CHR_DOLLAR) begin
        in_sentence <= 1'b0;
        hdr_pos     <= 3'd1;
      end else if (data_byte == rmc_pkg::CHR_CR) begin
        in_sentence <= 1'b0;
        hdr_pos     <= 3'd0;
      end else begin
        if (sentence_length < LEN_W'(MAX_SENTENCE_LEN)) begin
          sentence_length <= sentence_length + LEN_W'(1);
        end
        if (after_star != 2'd0) begin
          // checksum tail
          if (!hex[4] || after_star == 2'd3) begin
            bad_tail <= 1'b1;
          end else begin
            rx_csum    <= {rx_csum[3:0], hex[3:0]};
            after_star <= after_star + 2'd1;
          end
        end else if (data_byte == rmc_pkg::CHR_STAR) begin
          after_star <= 2'd1;
        end else begin
          xor_acc <= xor_acc ^ data_byte;
          if (data_byte == rmc_pkg::CHR_COMMA) begin
            if (comma_count != 4'd15) begin
              comma_count <= comma_count + 4'd1;
            end
            char_in_field <= 3'd0;
          end else begin
            if (comma_count == rmc_pkg::FIELD_TIME || comma_count == rmc_pkg::FIELD_DATE) begin
              if (char_in_field < 3'd6) begin
                digits[dig_idx] <= digit;
              end
            end else if (comma_count == rmc_pkg::FIELD_STATUS) begin
              fix_active <= (char_in_field == 3'd0) && (data_byte == rmc_pkg::CHR_FIX);
            end
            if (char_in_field != 3'd7) begin
              char_in_field <= char_in_field + 3'd1;
            end
          end
        end
      end
    end
  end

endmodule

/* rtl/rmc_fifo.sv */
// two-entry queue of closed sentences between parser and clock decision
// depends on rmc_pkg
`timescale 1ns / 1ps

module rmc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rmc_pkg::evt_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output rmc_pkg::evt_t pop_data
);

  rmc_pkg::evt_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign nonempty = count != 2'd0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/rmc_back.sv */
// clock-set decision and registered result stage
// depends on rmc_pkg
`timescale 1ns / 1ps

module rmc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             evt_nonempty,
  input  rmc_pkg::evt_t    evt_data,
  output logic             evt_pop,
  input  logic [5:0]       hourly_set_minute,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       sentence_status,
  output logic [6:0]       hour,
  output logic [6:0]       minute,
  output logic [6:0]       second,
  output logic [6:0]       day_of_month,
  output logic [6:0]       month_of_year,
  output logic [11:0]      full_year,
  output logic             set_clock
);

  logic clock_is_set;
  logic hourly_set_done;

  logic [7:0] hh;
  logic [7:0] mn;
  logic [7:0] ss;
  logic [7:0] dd;
  logic [7:0] mo;
  logic [7:0] yy;
  logic       is_ok;
  logic       at_set_minute;
  logic       do_set;

  assign hh = rmc_pkg::pair_value(evt_data.digits[0], evt_data.digits[1]);
  assign mn = rmc_pkg::pair_value(evt_data.digits[2], evt_data.digits[3]);
  assign ss = rmc_pkg::pair_value(evt_data.digits[4], evt_data.digits[5]);
  assign dd = rmc_pkg::pair_value(evt_data.digits[6], evt_data.digits[7]);
  assign mo = rmc_pkg::pair_value(evt_data.digits[8], evt_data.digits[9]);
  assign yy = rmc_pkg::pair_value(evt_data.digits[10], evt_data.digits[11]);

  assign evt_pop       = evt_nonempty && (!out_valid || out_ready);
  assign is_ok         = evt_data.status == rmc_pkg::ST_OK;
  assign at_set_minute = mn == {2'b00, hourly_set_minute};
  assign do_set        = at_set_minute ? !hourly_set_done : !clock_is_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      clock_is_set    <= 1'b0;
      hourly_set_done <= 1'b0;
    end else begin
      if (evt_pop) begin
        out_valid <= 1'b1;
        case (evt_data.status)
          rmc_pkg::ST_NOFIX, rmc_pkg::ST_SHORT: begin
            clock_is_set <= 1'b0;
          end
          rmc_pkg::ST_OK: begin
            if (at_set_minute) begin
              if (!hourly_set_done) begin
                hourly_set_done <= 1'b1;
              end
            end else if (clock_is_set) begin
              hourly_set_done <= 1'b0;
            end
            if (do_set) begin
              clock_is_set <= 1'b1;
            end
          end
          default: begin
            clock_is_set <= clock_is_set;
          end
        endcase
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt_pop) begin
      sentence_status <= evt_data.status;
      hour            <= is_ok ? hh[6:0] : 7'd0;
      minute          <= is_ok ? mn[6:0] : 7'd0;
      second          <= is_ok ? ss[6:0] : 7'd0;
      day_of_month    <= is_ok ? dd[6:0] : 7'd0;
      month_of_year   <= is_ok ? mo[6:0] : 7'd0;
      full_year       <= is_ok ? rmc_pkg::YEAR_BASE + {4'd0, yy} : 12'd0;
      set_clock       <= is_ok && do_set;
    end
  end

endmodule

/* rtl/nmea_rmc_time_parser_core.sv */
// Takes one received character per cycle while in_ready is high and parses
// $GPRMC sentences; a carriage return that closes a sentence yields one result
// (status, decoded time and date, clock-set request), which passes through the
// result queue into the output register once it is free. The parser accepts
// a byte every cycle as long as its two-entry result queue has room; the queue
// fills only while out_ready is held low, and the output register frees a slot
// in every cycle in which a result is taken. Configuration registers are
// written with cfg_we and are registered before they take effect.
// top level; depends on rmc_pkg, rmc_front, rmc_fifo, rmc_back
`timescale 1ns / 1ps

module nmea_rmc_time_parser_core #(
  parameter int MAX_SENTENCE_LEN = 127
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  sentence_status,
  output logic [6:0]  hour,
  output logic [6:0]  minute,
  output logic [6:0]  second,
  output logic [6:0]  day_of_month,
  output logic [6:0]  month_of_year,
  output logic [11:0] full_year,
  output logic        set_clock
);

  localparam logic CFG_HOURLY_SET_MINUTE   = 1'b0;
  localparam logic CFG_MIN_SENTENCE_LENGTH = 1'b1;

  logic [5:0] hourly_set_minute;
  logic [6:0] min_sentence_length;

  logic          evt_push;
  logic          evt_full;
  logic          evt_pop;
  logic          evt_nonempty;
  rmc_pkg::evt_t evt_in;
  rmc_pkg::evt_t evt_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      hourly_set_minute   <= 6'd59;
      min_sentence_length <= 7'd25;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOURLY_SET_MINUTE:   hourly_set_minute   <= cfg_data[5:0];
        CFG_MIN_SENTENCE_LENGTH: min_sentence_length <= cfg_data;
        default:                 min_sentence_length <= min_sentence_length;
      endcase
    end
  end

  rmc_front #(
    .MAX_SENTENCE_LEN(MAX_SENTENCE_LEN)
  ) u_front (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .data_byte           (data_byte),
    .min_sentence_length (min_sentence_length),
    .evt_full            (evt_full),
    .evt_push            (evt_push),
    .evt_data            (evt_in)
  );

  rmc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (evt_push),
    .push_data (evt_in),
    .full      (evt_full),
    .pop       (evt_pop),
    .nonempty  (evt_nonempty),
    .pop_data  (evt_out)
  );

  rmc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .evt_nonempty      (evt_nonempty),
    .evt_data          (evt_out),
    .evt_pop           (evt_pop),
    .hourly_set_minute (hourly_set_minute),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .sentence_status   (sentence_status),
    .hour              (hour),
    .minute            (minute),
    .second            (second),
    .day_of_month      (day_of_month),
    .month_of_year     (month_of_year),
    .full_year         (full_year),
    .set_clock         (set_clock)
  );

  // a clock-set request only comes with a good sentence
  a_set_needs_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && set_clock |-> sentence_status == rmc_pkg::ST_OK)
    else $error("set_clock on a failed sentence");

  // failed sentences carry zeroed time and date
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && sentence_status != rmc_pkg::ST_OK |->
      hour == 7'd0 && minute == 7'd0 && full_year == 12'd0)
    else $error("nonzero fields on a failed sentence");

  // good sentences carry a year offset from the base
  a_year_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && sentence_status == rmc_pkg::ST_OK |->
      full_year >= rmc_pkg::YEAR_BASE && full_year <= 12'd2165)
    else $error("year out of range");

  // a closing transaction never meets a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    evt_push |-> !evt_full)
    else $error("result queue overflow");

endmodule

/* tb/nmea_rmc_time_parser_core_tb.sv */
// self-checking testbench for nmea_rmc_time_parser_core: feeds $GPRMC sentences, noise and
// broken sentences, predicts every report with its own parser model and checks it
// depends on rmc_pkg and the rtl of nmea_rmc_time_parser_core
`timescale 1ns / 1ps

module nmea_rmc_time_parser_core_tb;

  localparam int MAX_LEN = 127;
  localparam int TOTAL_BYTES = 1900;
  localparam int HOLD_CYCLES = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 5000;

  localparam logic REG_SET_MINUTE = 1'b0;
  localparam logic REG_MIN_LENGTH = 1'b1;

  typedef enum int {
    FL_NONE, FL_NOFIX, FL_SHORT, FL_BADSUM, FL_ONEHEX, FL_THREEHEX,
    FL_NONHEX, FL_TWOSTAR, FL_NOSTAR, FL_LONG
  } sentence_flaw_t;

  typedef struct {
    rmc_pkg::status_t status;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [11:0] year;
    logic        set_clk;
  } rmc_report_t;

  class rmc_sentence_tracker;
    int unsigned errors;
    rmc_report_t pending_reports [$];
    logic [5:0]  set_minute;
    logic [6:0]  min_len;
    logic [2:0]  hunt_pos;
    bit          in_sentence;
    logic [3:0]  field_no;
    logic [2:0]  field_char;
    logic [6:0]  sent_len;
    logic [1:0]  star_state;
    logic [7:0]  xor_sum;
    logic [7:0]  rx_sum;
    bit          fix_seen;
    bit          clock_valid;
    bit          hour_set_done;
    int          digit_buf [12];

    function new();
      errors = 0;
      set_minute = 6'd59;
      min_len = 7'd25;
      hunt_pos = 3'd0;
      in_sentence = 1'b0;
      clock_valid = 1'b0;
      hour_set_done = 1'b0;
      open_sentence();
      in_sentence = 1'b0;
      hunt_pos = 3'd0;
    endfunction

    function void set_regs(logic [5:0] mn, logic [6:0] len);
      set_minute = mn;
      min_len = len;
    endfunction

    function int outstanding();
      return pending_reports.size();
    endfunction

    function int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
    endfunction

    function int pair(int k);
      return digit_buf[k] * 10 + digit_buf[k + 1];
    endfunction

    function void open_sentence();
      in_sentence = 1'b1;
      hunt_pos = 3'd6;
      field_no = 4'd0;
      field_char = 3'd0;
      sent_len = 7'd6;
      xor_sum = rmc_pkg::HDR_XOR;
      star_state = 2'd0;
      rx_sum = 8'd0;
      fix_seen = 1'b0;
      foreach (digit_buf[i]) digit_buf[i] = 0;
    endfunction

    function void close_sentence();
      rmc_report_t r;
      bit bad_tail;
      bit do_set;
      int mn;
      bad_tail = (hunt_pos == 3'd7);
      in_sentence = 1'b0;
      hunt_pos = 3'd0;
      r.hour = '0;
      r.minute = '0;
      r.second = '0;
      r.day = '0;
      r.month = '0;
      r.year = '0;
      r.set_clk = 1'b0;
      if (!fix_seen) begin
        r.status = rmc_pkg::ST_NOFIX;
        clock_valid = 1'b0;
      end else if (sent_len < min_len) begin
        r.status = rmc_pkg::ST_SHORT;
        clock_valid = 1'b0;
      end else if (bad_tail || star_state != 2'd3 || rx_sum != xor_sum) begin
        r.status = rmc_pkg::ST_CSUM;
      end else begin
        r.status = rmc_pkg::ST_OK;
        mn = pair(2);
        do_set = 1'b0;
        if (mn == int'(set_minute)) begin
          if (!hour_set_done) begin
            do_set = 1'b1;
            hour_set_done = 1'b1;
          end
        end else if (!clock_valid) begin
          do_set = 1'b1;
        end else begin
          hour_set_done = 1'b0;
        end
        if (do_set) clock_valid = 1'b1;
        r.hour = 7'(pair(0));
        r.minute = 7'(mn);
        r.second = 7'(pair(4));
        r.day = 7'(pair(6));
        r.month = 7'(pair(8));
        r.year = 12'(int'(rmc_pkg::YEAR_BASE) + pair(10));
        r.set_clk = do_set;
      end
      pending_reports.insert(pending_reports.size(), r);
    endfunction

    function void note_byte(logic [7:0] c);
      logic [2:0] pos;
      int h;
      int k;
      if (!in_sentence) begin
        pos = (hunt_pos >= 3'd6) ? 3'd0 : hunt_pos;
        if (c == rmc_pkg::HDR_CHARS[pos]) begin
          pos++;
          if (pos == 3'd6) open_sentence();
          else hunt_pos = pos;
        end else begin
          hunt_pos = (c == rmc_pkg::CHR_DOLLAR) ? 3'd1 : 3'd0;
        end
        return;
      end
      // a new header mid-sentence drops the open one
      if (c == rmc_pkg::CHR_DOLLAR) begin
        in_sentence = 1'b0;
        hunt_pos = 3'd1;
        return;
      end
      if (c == rmc_pkg::CHR_CR) begin
        close_sentence();
        return;
      end
      if (sent_len < MAX_LEN) sent_len++;
      if (star_state != 2'd0) begin
        h = hex_digit(c);
        if (h < 0 || star_state == 2'd3) begin
          hunt_pos = 3'd7;
        end else begin
          rx_sum = {rx_sum[3:0], 4'(h)};
          star_state++;
        end
        return;
      end
      if (c == rmc_pkg::CHR_STAR) begin
        star_state = 2'd1;
        return;
      end
      xor_sum ^= c;
      if (c == rmc_pkg::CHR_COMMA) begin
        if (field_no != 4'hF) field_no++;
        field_char = 3'd0;
        return;
      end
      if (field_no == rmc_pkg::FIELD_TIME || field_no == rmc_pkg::FIELD_DATE) begin
        if (field_char < 3'd6) begin
          k = int'(field_char) + ((field_no == rmc_pkg::FIELD_DATE) ? 6 : 0);
          digit_buf[k] = (c >= rmc_pkg::CHR_ZERO && c <= rmc_pkg::CHR_NINE) ?
                         int'(c - rmc_pkg::CHR_ZERO) : 0;
        end
      end else if (field_no == rmc_pkg::FIELD_STATUS) begin
        fix_seen = (field_char == 3'd0 && c == rmc_pkg::CHR_FIX);
      end
      if (field_char != 3'd7) field_char++;
    endfunction

    function void compare_field(string name, int expv, int gotv);
      if (expv != gotv) begin
        $error("%s: expected %0d, got %0d", name, expv, gotv);
        errors++;
      end
    endfunction

    function void check_report(rmc_report_t got);
      rmc_report_t want;
      if (pending_reports.size() == 0) begin
        $error("report transaction with no sentence pending");
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("sentence_status", int'(want.status), int'(got.status));
      compare_field("hour", int'(want.hour), int'(got.hour));
      compare_field("minute", int'(want.minute), int'(got.minute));
      compare_field("second", int'(want.second), int'(got.second));
      compare_field("day_of_month", int'(want.day), int'(got.day));
      compare_field("month_of_year", int'(want.month), int'(got.month));
      compare_field("full_year", int'(want.year), int'(got.year));
      compare_field("set_clock", int'(want.set_clk), int'(got.set_clk));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        cfg_we;
  logic        cfg_index;
  logic [6:0]  cfg_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  sentence_status;
  logic [6:0]  hour;
  logic [6:0]  minute;
  logic [6:0]  second;
  logic [6:0]  day_of_month;
  logic [6:0]  month_of_year;
  logic [11:0] full_year;
  logic        set_clock;

  rmc_sentence_tracker sb;
  int          fed_bytes;
  int          burst_left;
  bit          gaps_on;
  bit          hold_request;
  logic [5:0]  cur_set_minute;
  int          idle_cycles;

  nmea_rmc_time_parser_core dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sentence_status (sentence_status),
    .hour            (hour),
    .minute          (minute),
    .second          (second),
    .day_of_month    (day_of_month),
    .month_of_year   (month_of_year),
    .full_year       (full_year),
    .set_clock       (set_clock)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_byte(data_byte);
  end

  always @(posedge clk) begin : report_monitor
    rmc_report_t seen;
    if (!rst && out_valid && out_ready) begin
      seen.status = rmc_pkg::status_t'(sentence_status);
      seen.hour = hour;
      seen.minute = minute;
      seen.second = second;
      seen.day = day_of_month;
      seen.month = month_of_year;
      seen.year = full_year;
      seen.set_clk = set_clock;
      sb.check_report(seen);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // report sink: random stall segments, plus one long hold-off on request
  initial begin : report_sink
    int seg_len;
    int stall_pct;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        seg_len = $urandom_range(1, 60);
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
        for (int i = 0; i < seg_len && !hold_request; i++) begin
          out_ready <= ($urandom_range(99) >= stall_pct);
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_paced(input logic [7:0] b);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    fed_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_paced(s[i]);
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_paced(8'($urandom_range(255)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [5:0] mn, input logic [6:0] len);
    cfg_we <= 1'b1;
    cfg_index <= REG_SET_MINUTE;
    cfg_data <= {1'b0, mn};
    @(posedge clk);
    cfg_index <= REG_MIN_LENGTH;
    cfg_data <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_regs(mn, len);
    cur_set_minute = mn;
  endtask

  function automatic string filler_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == rmc_pkg::CHR_DOLLAR || b == rmc_pkg::CHR_STAR || b == rmc_pkg::CHR_COMMA ||
           b == rmc_pkg::CHR_CR);
    return $sformatf("%c", b);
  endfunction

  function automatic string rand_text(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++)
      s = {s, ($urandom_range(9) == 0) ? filler_char() : $sformatf("%0d", $urandom_range(9))};
    return s;
  endfunction

  // text between '$' and '*'
  function automatic string make_body(sentence_flaw_t flaw, int mn, bit compact);
    string tf;
    string st;
    string df;
    string s;
    if ($urandom_range(9) == 0) tf = rand_text($urandom_range(0, 8));
    else tf = $sformatf("%02d%02d%02d", $urandom_range(23), mn, $urandom_range(59));
    if ($urandom_range(2) == 0) tf = {tf, ".00"};
    st = "A";
    if (flaw == FL_NOFIX) begin
      case ($urandom_range(3))
        0: st = "V";
        1: st = "";
        2: st = "AA";
        default: st = "a";
      endcase
    end
    if ($urandom_range(9) == 0) df = rand_text($urandom_range(0, 8));
    else df = $sformatf("%02d%02d%02d", $urandom_range(1, 31), $urandom_range(1, 12),
                        $urandom_range(99));
    s = {"GPRMC,", tf, ",", st};
    if (flaw == FL_SHORT) return s;
    if (compact) s = {s, ",,,,,,,", df, ","};
    else s = {s, ",", rand_text(8), ",N,", rand_text(9), ",E,", rand_text(5), ",",
              rand_text(5), ",", df, ",", rand_text(4), ",W"};
    if ($urandom_range(3) == 0) s = {s, ",A"};
    if (flaw == FL_LONG) s = {s, ",", rand_text(100), ",,,,,,,,"};
    return s;
  endfunction

  function automatic string make_tail(sentence_flaw_t flaw, string body);
    logic [7:0] x;
    string hx;
    string bad;
    x = 8'h00;
    for (int i = 0; i < body.len(); i++) x ^= body[i];
    bad = "/:@G`g";
    if (flaw == FL_BADSUM || ((flaw == FL_NOFIX || flaw == FL_SHORT) && $urandom_range(1) == 0))
      x ^= 8'($urandom_range(1, 255));
    hx = ($urandom_range(2) == 0) ? $sformatf("%02x", x) : $sformatf("%02X", x);
    case (flaw)
      FL_ONEHEX:   return {"*", hx.substr(0, 0)};
      FL_THREEHEX: return {"*", hx, $sformatf("%1X", $urandom_range(15))};
      FL_NONHEX:   return {"*", hx.substr(0, 0), $sformatf("%c", bad[$urandom_range(5)])};
      FL_TWOSTAR:  return {"*", hx, "*"};
      FL_NOSTAR:   return "";
      default:     return {"*", hx};
    endcase
  endfunction

  task automatic send_sentence(input sentence_flaw_t flaw, input int mn);
    string body;
    string tail;
    body = make_body(flaw, mn, $urandom_range(1) == 0);
    tail = make_tail(flaw, body);
    send_paced(rmc_pkg::CHR_DOLLAR);
    send_text(body);
    send_text(tail);
    send_paced(rmc_pkg::CHR_CR);
  endtask

  // sentence cut off before its end, left open
  task automatic send_cut_sentence(input int mn);
    string body;
    body = make_body(FL_NONE, mn, 1'b1);
    send_paced(rmc_pkg::CHR_DOLLAR);
    send_text(body.substr(0, $urandom_range(0, body.len() - 1)));
  endtask

  initial begin : stimulus
    int pick;
    int mn;
    int phase;
    logic [5:0] mn_cfg;
    logic [6:0] len_cfg;
    sb = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= 8'h00;
    cfg_we <= 1'b0;
    cfg_index <= REG_SET_MINUTE;
    cfg_data <= 7'd0;
    fed_bytes = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    hold_request = 1'b0;
    cur_set_minute = 6'd59;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: stray bytes, header restarts, clock decision and every tail defect
    send_paced(rmc_pkg::CHR_CR);
    send_paced(8'h00);
    send_paced(8'hFF);
    send_paced(8'h80);
    send_text("$GP$GPR");
    send_sentence(FL_NONE, 10);
    send_sentence(FL_NONE, 59);
    send_sentence(FL_NONE, 59);
    send_sentence(FL_NONE, 11);
    send_sentence(FL_NONE, 59);
    send_sentence(FL_NOFIX, 12);
    send_sentence(FL_NONE, 12);
    send_sentence(FL_SHORT, 13);
    send_sentence(FL_BADSUM, 14);
    send_sentence(FL_ONEHEX, 15);
    send_sentence(FL_THREEHEX, 16);
    send_sentence(FL_NONHEX, 17);
    send_sentence(FL_TWOSTAR, 18);
    send_sentence(FL_NOSTAR, 19);
    send_sentence(FL_LONG, 20);
    send_cut_sentence(21);
    send_sentence(FL_NONE, 22);
    send_cut_sentence(23);
    send_paced(rmc_pkg::CHR_CR);
    drain();
    program_regs(6'd0, 7'd0);
    send_sentence(FL_SHORT, 0);
    send_sentence(FL_NONE, 0);
    send_sentence(FL_NONE, 0);
    drain();
    program_regs(6'd59, 7'd127);
    send_sentence(FL_NONE, 59);
    send_sentence(FL_LONG, 59);

    // random phases, each under its own register setting
    phase = 0;
    do begin
      drain();
      case ($urandom_range(3))
        0: mn_cfg = 6'd0;
        1: mn_cfg = 6'd59;
        default: mn_cfg = 6'($urandom_range(59));
      endcase
      case ($urandom_range(7))
        0: len_cfg = 7'd0;
        1: len_cfg = 7'd127;
        2, 3: len_cfg = 7'd25;
        default: len_cfg = 7'($urandom_range(18, 60));
      endcase
      program_regs(mn_cfg, len_cfg);
      gaps_on = ($urandom_range(3) != 0);
      if (phase == 0) begin
        // sink holds off while short sentences keep coming
        gaps_on = 1'b0;
        hold_request = 1'b1;
        repeat (8) send_sentence(FL_SHORT, cur_set_minute);
      end
      repeat ($urandom_range(4, 10)) begin
        if ($urandom_range(6) == 0) send_noise($urandom_range(1, 6));
        pick = $urandom_range(99);
        if ($urandom_range(2) == 0) mn = cur_set_minute;
        else if ($urandom_range(19) == 0) mn = $urandom_range(60, 99);
        else mn = $urandom_range(59);
        if (pick < 58) send_sentence(FL_NONE, mn);
        else if (pick < 65) send_sentence(FL_NOFIX, mn);
        else if (pick < 70) send_sentence(FL_SHORT, mn);
        else if (pick < 76) send_sentence(FL_BADSUM, mn);
        else if (pick < 79) send_sentence(FL_ONEHEX, mn);
        else if (pick < 82) send_sentence(FL_THREEHEX, mn);
        else if (pick < 85) send_sentence(FL_NONHEX, mn);
        else if (pick < 88) send_sentence(FL_TWOSTAR, mn);
        else if (pick < 91) send_sentence(FL_NOSTAR, mn);
        else if (pick < 95) send_sentence(FL_LONG, mn);
        else begin
          send_cut_sentence(mn);
          send_sentence(FL_NONE, mn);
        end
      end
      phase++;
    end while (fed_bytes < TOTAL_BYTES);

    drain();
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
